[rtl/core/psr_pkg.sv]
// Shared types and constants for the perfect square root block.
`timescale 1ns / 1ps
`default_nettype none

package psr_pkg;

    // Field widths
    localparam int unsigned ValueWidth = 32;
    localparam int unsigned RootWidth  = 16;

    // Leading trial bit of the digit-by-digit root: bit 30 for a 32-bit radicand
    localparam logic [ValueWidth-1:0] FirstBit = {2'b01, {(ValueWidth-2){1'b0}}};

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture a new item and start the root
        logic step;   // settle one root digit
        logic emit;   // move the checked root into the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last;   // current step settles the final digit
    } status_t;

endpackage

`default_nettype wire

[rtl/core/psr_datapath.sv]
// Datapath for the perfect square root: digit-by-digit root and exactness check.
`timescale 1ns / 1ps
`default_nettype none

module psr_datapath (
    input  wire logic                             clk,
    input  wire psr_pkg::cmd_t                    cmd,
    input  wire logic [psr_pkg::ValueWidth-1:0]   value,
    output psr_pkg::status_t                      status,
    output logic [psr_pkg::RootWidth-1:0]         root
);

    logic [psr_pkg::ValueWidth-1:0] rem_reg, rem_next;
    logic [psr_pkg::ValueWidth-1:0] res_reg, res_next;
    logic [psr_pkg::ValueWidth-1:0] bit_reg, bit_next;
    logic                           neg_reg, neg_next;
    logic [psr_pkg::RootWidth-1:0]  root_reg, root_next;
    logic [psr_pkg::ValueWidth-1:0] trial;
    logic                           exact;

    // Try the next digit against the remainder
    assign trial = res_reg + bit_reg;

    // Remainder is value minus root squared once all digits are settled
    assign exact = (rem_reg == '0) && !neg_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        neg_next  = neg_reg;
        root_next = root_reg;
        if (cmd.load)
        begin
            rem_next = value;
            res_next = '0;
            bit_next = psr_pkg::FirstBit;
            neg_next = value[psr_pkg::ValueWidth-1];
        end
        else if (cmd.step)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
        if (cmd.emit)
        begin
            root_next = exact ? res_reg[psr_pkg::RootWidth-1:0] : '0;
        end
    end

    // Hold payload registers; no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        neg_reg  <= neg_next;
        root_reg <= root_next;
    end

    assign status.last = bit_reg[0];
    assign root        = root_reg;

endmodule

`default_nettype wire

[rtl/core/psr_ctrl.sv]
// Controller for the perfect square root: sequences load, digit steps and output.
`timescale 1ns / 1ps
`default_nettype none

module psr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire psr_pkg::status_t  status,
    output psr_pkg::cmd_t          cmd
);

    psr_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    // Output register may be refilled when empty or being taken
    assign out_free = !out_valid_reg || out_ready;

    // Advance state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            psr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = psr_pkg::ST_RUN;
                end
            end
            psr_pkg::ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = psr_pkg::ST_FINISH;
                end
            end
            psr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = psr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // An emitted result is offered in the next cycle
    a_emit_offers: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not offered");

    // An accepted item starts the digit steps
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == psr_pkg::ST_RUN))
        else $error("accepted item did not start");

    // The final digit leads to the output stage
    a_last_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psr_pkg::ST_RUN && status.last) |=>
        (state_reg == psr_pkg::ST_FINISH))
        else $error("final digit did not finish");

    // Never overwrite a result that waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

endmodule

`default_nettype wire

[rtl/core/perfect_square_root.sv]
// Top level of the perfect square root block: controller plus datapath.
//
//  channel  signals                         width  direction
//  input    in_valid, in_ready, value       32     value signed
//  output   out_valid, out_ready, root      16     root unsigned
//
// One item is taken at a time: it is loaded, the datapath runs its sixteen-step
// digit-by-digit root loop, then the root is checked and registered in the output
// register when it is free; only then is the next item taken.
// A result waits in the output register; a stalled output holds the finished
// root in the datapath until the register frees up. Reset clears control only.
`timescale 1ns / 1ps
`default_nettype none

module perfect_square_root (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [psr_pkg::ValueWidth-1:0]  value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [psr_pkg::RootWidth-1:0]        root
);

    psr_pkg::cmd_t    cmd;
    psr_pkg::status_t status;

    // Sequence the item
    psr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Compute and check the root
    psr_datapath u_datapath (
        .clk    (clk),
        .cmd    (cmd),
        .value  (value),
        .status (status),
        .root   (root)
    );

endmodule

`default_nettype wire

[bench/perfect_square_root_checker.sv]
// Result checker for the perfect square root block: predicts each root and compares.
`timescale 1ns / 1ps

module perfect_square_root_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [psr_pkg::ValueWidth-1:0]    value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [psr_pkg::RootWidth-1:0]     root,
    output int                                failures,
    output int                                roots_pending,
    output int                                roots_checked,
    output int                                exact_roots_seen
);

    localparam int ReportLimit = 10;

    logic [psr_pkg::RootWidth-1:0] expected_roots[$];

    // Exact root of a signed value: floor root two bits at a time, then square check
    function automatic logic [psr_pkg::RootWidth-1:0] exact_root(
        input logic [psr_pkg::ValueWidth-1:0] radicand
    );
        logic [31:0] remainder;
        logic [31:0] partial;
        logic [31:0] trial;
        remainder = radicand;
        partial   = '0;
        trial     = 32'h4000_0000;
        // Negative values have no root
        if (radicand[psr_pkg::ValueWidth-1])
            return '0;
        for (int digit = 0; digit < 16; digit++)
        begin
            if (remainder >= partial + trial)
            begin
                remainder = remainder - (partial + trial);
                partial   = (partial >> 1) + trial;
            end
            else
            begin
                partial = partial >> 1;
            end
            trial = trial >> 2;
        end
        // Drop the root unless it squares back to the value
        if (partial * partial != radicand)
            return '0;
        return partial[psr_pkg::RootWidth-1:0];
    endfunction

    initial
    begin
        failures         = 0;
        roots_pending    = 0;
        roots_checked    = 0;
        exact_roots_seen = 0;
    end

    always @(posedge clk)
    begin
        logic [psr_pkg::RootWidth-1:0] predicted;
        if (rst_n)
        begin
            // Queue the prediction for each accepted item
            if (in_valid && in_ready)
                expected_roots.push_back(exact_root(value));

            // Compare each accepted result with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_roots.size() == 0)
                begin
                    failures++;
                    if (failures <= ReportLimit)
                        $display("%0t: unexpected root %0d with no item pending", $time, root);
                end
                else
                begin
                    predicted = expected_roots.pop_front();
                    roots_checked++;
                    if (root != 0)
                        exact_roots_seen++;
                    if (root !== predicted)
                    begin
                        failures++;
                        if (failures <= ReportLimit)
                            $display("%0t: root mismatch, expected %0d got %0d",
                                     $time, predicted, root);
                    end
                end
            end
            roots_pending = expected_roots.size();
        end
    end

endmodule

[bench/perfect_square_root_tb.sv]
// Testbench top for the perfect square root block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module perfect_square_root_tb;

    localparam int RandomItems = 1800;
    localparam int IdleLimit   = 5000;
    localparam int TailCycles  = 40;
    localparam int MaxSquareRoot = 46340;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [psr_pkg::ValueWidth-1:0] value     = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [psr_pkg::RootWidth-1:0]  root;

    int failures;
    int roots_pending;
    int roots_checked;
    int exact_roots_seen;
    int items_sent = 0;
    int negatives_sent = 0;
    bit steady = 1'b0;

    perfect_square_root uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root      (root)
    );

    perfect_square_root_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .value            (value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .root             (root),
        .failures         (failures),
        .roots_pending    (roots_pending),
        .roots_checked    (roots_checked),
        .exact_roots_seen (exact_roots_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly short, now and then long, none in steady stretches
    function automatic int pick_gap();
        if (steady)
            return 0;
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    // Present one item and hold it until accepted
    task automatic send_value(input logic [psr_pkg::ValueWidth-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (v[psr_pkg::ValueWidth-1])
            negatives_sent++;
    endtask

    // Random value: mostly exact squares and their neighbours, some noise
    function automatic logic [psr_pkg::ValueWidth-1:0] random_value();
        logic [31:0] base;
        int pick;
        pick = $urandom_range(0, 99);
        base = $urandom_range(0, MaxSquareRoot);
        if (pick < 40)
            return base * base;
        if (pick < 60)
        begin
            if ($urandom_range(0, 1))
                return base * base + $urandom_range(1, 3);
            return base * base - $urandom_range(1, 3);
        end
        if (pick < 80)
            return $urandom;
        if (pick < 90)
            return {1'b1, 31'($urandom)};
        return $urandom_range(0, 100);
    endfunction

    // Output side: ready stretches broken by stalls
    initial
    begin
        int on_cycles;
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            on_cycles = $urandom_range(1, 12);
            stall     = pick_gap();
            out_ready <= 1'b1;
            repeat (on_cycles) @(posedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run after too long without any item moving
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", IdleLimit);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [psr_pkg::ValueWidth-1:0] directed[$];
        directed = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
            32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
            32'd2147395600, 32'd2147395599, 32'd2147395601, 32'd2147302921,
            32'h4000_0000, 32'h3FFF_FFFF, 32'd1073676289, 32'd65536, 32'd65535
        };

        // Hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edges of the field, negatives, zero and one, near squares
        foreach (directed[i])
            send_value(directed[i]);

        // Random, with two stretches free of idling
        for (int n = 0; n < RandomItems; n++)
        begin
            steady = (n >= 600 && n < 800) || (n >= 1400 && n < 1500);
            send_value(random_value());
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (roots_pending != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        $display("sent %0d items (%0d negative), checked %0d roots, %0d of them exact and nonzero",
                 items_sent, negatives_sent, roots_checked, exact_roots_seen);
        $display("failures: %0d, roots still awaited: %0d", failures, roots_pending);
        if (failures == 0 && roots_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
